/* design/ldw_pkg.sv */
`timescale 1ns / 1ps
// Shared types, constants and helpers for the local translation warp block.
// No dependencies.
package ldw_pkg;

    localparam int CoordW        = 16;
    localparam int DimW          = 13;
    localparam int CoordFracBits = 4;
    localparam int MaxDim        = 4096;
    localparam int FracW         = 24;
    localparam int QuoW          = FracW + 1;
    localparam int DenW          = 34;
    localparam int NormW         = 40;
    localparam int FifoDepth     = 4;

    typedef enum logic [2:0] {
        REG_START_X  = 3'd0,
        REG_START_Y  = 3'd1,
        REG_END_X    = 3'd2,
        REG_END_Y    = 3'd3,
        REG_RADIUS   = 3'd4,
        REG_DAMP     = 3'd5,
        REG_WIDTH    = 3'd6,
        REG_HEIGHT   = 3'd7
    } t_cfg_idx;

    typedef struct packed {
        logic [CoordW-1:0] start_x;
        logic [CoordW-1:0] start_y;
        logic [CoordW-1:0] end_x;
        logic [CoordW-1:0] end_y;
        logic [CoordW-1:0] radius;
        logic              damp;
    } t_cfg;

    // One classified item as it travels from front to back.
    typedef struct packed {
        logic [CoordW-1:0]        px;
        logic [CoordW-1:0]        py;
        logic signed [CoordW:0]   mx;
        logic signed [CoordW:0]   my;
        logic [2*CoordW-1:0]      e;
        logic [DenW-1:0]          den;
        logic [DenW-1:0]          u;
        logic [DenW-1:0]          m2sq;
        logic [2*CoordW-1:0]      rsq;
        logic                     in_circ;
        logic                     move;
        logic                     damp;
    } t_item;

    // Upper clamp bound in Q format for one image dimension.
    function automatic logic [CoordW-1:0] clamp_limit(input logic [DimW-1:0] dim);
        logic [31:0] d32;
        logic [31:0] l32;
        d32 = {{(32-DimW){1'b0}}, dim};
        if (d32 == 32'd0) d32 = 32'd1;
        if (d32 > 32'(MaxDim)) d32 = 32'(MaxDim);
        l32 = (d32 - 32'd1) << CoordFracBits;
        return (l32 > 32'hFFFF) ? 16'hFFFF : l32[CoordW-1:0];
    endfunction

endpackage

/* design/ldw_front.sv */
`timescale 1ns / 1ps
// Front end: squared distances, inside test and drag terms for one point.
// Depends on ldw_pkg.
module ldw_front (
    input  logic [ldw_pkg::CoordW-1:0] i_x,
    input  logic [ldw_pkg::CoordW-1:0] i_y,
    input  ldw_pkg::t_cfg              i_cfg,
    output ldw_pkg::t_item             o_item
);
    import ldw_pkg::*;

    logic signed [CoordW:0]     cx, cy, ex, ey, mx, my;
    logic signed [2*CoordW+1:0] cx2, cy2, ex2, ey2, mx2, my2;
    logic signed [2*CoordW+2:0] dot;
    logic [DenW-1:0]            csq, msq, m2sq;
    logic [2*CoordW-1:0]        rsq, e;
    logic                       in_circ;

    assign cx = $signed({1'b0, i_x}) - $signed({1'b0, i_cfg.start_x});
    assign cy = $signed({1'b0, i_y}) - $signed({1'b0, i_cfg.start_y});
    assign ex = $signed({1'b0, i_x}) - $signed({1'b0, i_cfg.end_x});
    assign ey = $signed({1'b0, i_y}) - $signed({1'b0, i_cfg.end_y});
    assign mx = $signed({1'b0, i_cfg.end_x}) - $signed({1'b0, i_cfg.start_x});
    assign my = $signed({1'b0, i_cfg.end_y}) - $signed({1'b0, i_cfg.start_y});

    assign cx2 = cx * cx;
    assign cy2 = cy * cy;
    assign ex2 = ex * ex;
    assign ey2 = ey * ey;
    assign mx2 = mx * mx;
    assign my2 = my * my;
    assign dot = mx * cx + my * cy;

    assign csq  = $unsigned(cx2) + $unsigned(cy2);
    assign msq  = $unsigned(ex2) + $unsigned(ey2);
    assign m2sq = $unsigned(mx2) + $unsigned(my2);
    assign rsq  = i_cfg.radius * i_cfg.radius;

    assign in_circ = csq < {2'b00, rsq};
    assign e       = in_circ ? (rsq - csq[2*CoordW-1:0]) : '0;

    always_comb begin
        o_item.px      = i_x;
        o_item.py      = i_y;
        o_item.mx      = mx;
        o_item.my      = my;
        o_item.e       = e;
        o_item.den     = {2'b00, e} + msq;
        o_item.u       = dot[2*CoordW+2] ? DenW'(-dot) : DenW'(dot);
        o_item.m2sq    = m2sq;
        o_item.rsq     = rsq;
        o_item.in_circ = in_circ;
        o_item.move    = in_circ && (m2sq != '0);
        o_item.damp    = i_cfg.damp && in_circ && (m2sq != '0);
    end

endmodule

/* design/ldw_fifo.sv */
`timescale 1ns / 1ps
// Short queue that decouples the front end from the back-end pipeline.
// Depends on ldw_pkg.
module ldw_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  ldw_pkg::t_item i_data,
    input  logic           i_pop,
    output ldw_pkg::t_item o_data,
    output logic           o_full,
    output logic           o_empty
);
    import ldw_pkg::*;

    localparam int AW = $clog2(FifoDepth);

    t_item         r_mem [FifoDepth];
    logic [AW-1:0] r_wp, r_rp;
    logic [AW:0]   r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) r_wp <= r_wp + 1'b1;
            if (i_pop)  r_rp <= r_rp + 1'b1;
            if (i_push && !i_pop) r_count <= r_count + 1'b1;
            else if (!i_push && i_pop) r_count <= r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_data;
    end

    assign o_data  = r_mem[r_rp];
    assign o_full  = r_count == (AW+1)'(FifoDepth);
    assign o_empty = r_count == '0;

`ifndef ASSERT_OFF
    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= (AW+1)'(FifoDepth)) else $error("queue overfilled");
    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> r_count != '0) else $error("pop from empty queue");
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> r_count != (AW+1)'(FifoDepth)) else $error("push into full queue");
    a_count_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !i_pop) |=> r_count == $past(r_count) + 1'b1)
        else $error("queue count lost a push");
`endif

endmodule

/* design/ldw_div.sv */
`timescale 1ns / 1ps
// Pipelined restoring divider: quotient of (num << 24) / den, one bit a stage.
// Expects num <= den. Depends on ldw_pkg.
module ldw_div #(
    parameter int DW = ldw_pkg::DenW,
    parameter int PW = 8
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_en,
    input  logic                     i_valid,
    input  logic [DW-1:0]            i_num,
    input  logic [DW-1:0]            i_den,
    input  logic [PW-1:0]            i_pay,
    output logic                     o_valid,
    output logic [ldw_pkg::QuoW-1:0] o_quo,
    output logic [PW-1:0]            o_pay
);
    import ldw_pkg::*;

    localparam int NS = QuoW;

    logic [DW-1:0]   r_rem [NS];
    logic [DW-1:0]   r_den [NS];
    logic [QuoW-1:0] r_quo [NS];
    logic [PW-1:0]   r_pay [NS];
    logic [NS-1:0]   r_vld;

    logic [DW-1:0]   n_rem [NS];
    logic [QuoW-1:0] n_quo [NS];

    always_comb begin
        logic [DW:0] sh;
        logic [DW:0] diff;
        logic        ge;
        ge       = i_num >= i_den;
        n_rem[0] = ge ? (i_num - i_den) : i_num;
        n_quo[0] = {{(QuoW-1){1'b0}}, ge};
        for (int k = 1; k < NS; k++) begin
            sh       = {r_rem[k-1], 1'b0};
            diff     = sh - {1'b0, r_den[k-1]};
            ge       = sh >= {1'b0, r_den[k-1]};
            n_rem[k] = ge ? diff[DW-1:0] : sh[DW-1:0];
            n_quo[k] = {r_quo[k-1][QuoW-2:0], ge};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[NS-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= n_rem[0];
            r_quo[0] <= n_quo[0];
            r_den[0] <= i_den;
            r_pay[0] <= i_pay;
            for (int k = 1; k < NS; k++) begin
                r_rem[k] <= n_rem[k];
                r_quo[k] <= n_quo[k];
                r_den[k] <= r_den[k-1];
                r_pay[k] <= r_pay[k-1];
            end
        end
    end

    assign o_valid = r_vld[NS-1];
    assign o_quo   = r_quo[NS-1];
    assign o_pay   = r_pay[NS-1];

endmodule

/* design/ldw_back.sv */
`timescale 1ns / 1ps
// Back end: weight division, damping, displacement and clamping pipeline.
// Depends on ldw_pkg and ldw_div.
module ldw_back (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_avail,
    input  ldw_pkg::t_item             i_item,
    output logic                       o_pop,
    input  logic [ldw_pkg::CoordW-1:0] i_lim_x,
    input  logic [ldw_pkg::CoordW-1:0] i_lim_y,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic [ldw_pkg::CoordW-1:0] o_x_out,
    output logic [ldw_pkg::CoordW-1:0] o_y_out,
    output logic                       o_inside_res
);
    import ldw_pkg::*;

    localparam int WideW = 68;
    localparam int HalfW = 17;
    localparam int NSq   = 6;

    typedef struct packed {
        logic [CoordW-1:0]      px;
        logic [CoordW-1:0]      py;
        logic signed [CoordW:0] mx;
        logic signed [CoordW:0] my;
        logic [QuoW-1:0]        a;
        logic                   in_circ;
        logic                   move;
        logic                   go;
    } t_mid;

    typedef struct packed {
        t_mid                  m;
        logic                  unz;
        logic [2*HalfW-1:0]    hh, hl, ll;
        logic [HalfW+31:0]     ph, pl;
    } t_sa;

    typedef struct packed {
        t_mid             m;
        logic             unz;
        logic [WideW-1:0] t;
        logic [WideW-1:0] d;
    } t_sb;

    typedef struct packed {
        t_mid             m;
        logic [WideW-1:0] t;
        logic [WideW-1:0] d;
        logic [6:0]       s;
    } t_sc;

    typedef struct packed {
        logic signed [CoordW+1:0] rx;
        logic signed [CoordW+1:0] ry;
        logic                     in_circ;
    } t_sg;

    logic en;

    // Global advance: move everything unless the output beat is held.
    assign en    = !o_out_valid || !i_out_stall;
    assign o_pop = en && i_avail;

    // Weight quotient e / (e + msq).
    logic            d1_vld;
    logic [QuoW-1:0] d1_quo;
    logic [$bits(t_item)-1:0] d1_raw;
    t_item           d1_item;

    ldw_div #(.DW(DenW), .PW($bits(t_item))) u_div_w (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_avail),
        .i_num   ({2'b00, i_item.e}),
        .i_den   (i_item.den),
        .i_pay   (i_item),
        .o_valid (d1_vld),
        .o_quo   (d1_quo),
        .o_pay   (d1_raw)
    );
    assign d1_item = t_item'(d1_raw);

    // Stage A: square the weight, split the wide products.
    logic              r_sa_vld;
    t_sa               r_sa;
    logic [2*QuoW-1:0] qq;
    t_sa               n_sa;

    assign qq = d1_quo * d1_quo;

    always_comb begin
        n_sa.m.px      = d1_item.px;
        n_sa.m.py      = d1_item.py;
        n_sa.m.mx      = d1_item.mx;
        n_sa.m.my      = d1_item.my;
        n_sa.m.a       = qq[FracW+QuoW-1:FracW];
        n_sa.m.in_circ = d1_item.in_circ;
        n_sa.m.move    = d1_item.move;
        n_sa.m.go      = d1_item.damp;
        n_sa.unz       = d1_item.u != '0;
        n_sa.hh        = d1_item.u[2*HalfW-1:HalfW] * d1_item.u[2*HalfW-1:HalfW];
        n_sa.hl        = d1_item.u[2*HalfW-1:HalfW] * d1_item.u[HalfW-1:0];
        n_sa.ll        = d1_item.u[HalfW-1:0] * d1_item.u[HalfW-1:0];
        n_sa.ph        = d1_item.m2sq[2*HalfW-1:HalfW] * d1_item.rsq;
        n_sa.pl        = d1_item.m2sq[HalfW-1:0] * d1_item.rsq;
    end

    // Stage B: assemble the squared projection and its bound.
    logic r_sb_vld;
    t_sb  r_sb;
    t_sb  n_sb;

    always_comb begin
        n_sb.m   = r_sa.m;
        n_sb.unz = r_sa.unz;
        n_sb.t   = ({34'd0, r_sa.hh} << (2*HalfW)) + ({34'd0, r_sa.hl} << (HalfW+1))
                 + {34'd0, r_sa.ll};
        n_sb.d   = ({19'd0, r_sa.ph} << HalfW) + {19'd0, r_sa.pl};
    end

    // Stage C: damping test and normalizing shift.
    logic r_sc_vld;
    t_sc  r_sc;
    t_sc  n_sc;

    always_comb begin
        logic [6:0] len;
        len = '0;
        for (int i = 0; i < WideW; i++) begin
            if (r_sb.d[i]) len = 7'(i + 1);
        end
        n_sc.m    = r_sb.m;
        n_sc.m.go = r_sb.m.go && r_sb.unz && (r_sb.t < r_sb.d);
        n_sc.t    = r_sb.t;
        n_sc.d    = r_sb.d;
        n_sc.s    = (len > 7'(NormW)) ? (len - 7'(NormW)) : 7'd0;
    end

    // Projection quotient.
    logic [NormW-1:0] tn, dn;
    logic             d2_vld;
    logic [QuoW-1:0]  d2_quo;
    logic [$bits(t_mid)-1:0] d2_raw;
    t_mid             d2_mid;
    logic [WideW-1:0] t_sh, d_sh;

    assign t_sh = r_sc.t >> r_sc.s;
    assign d_sh = r_sc.d >> r_sc.s;
    assign tn   = t_sh[NormW-1:0];
    assign dn   = d_sh[NormW-1:0];

    ldw_div #(.DW(NormW), .PW($bits(t_mid))) u_div_p (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_sc_vld),
        .i_num   (tn),
        .i_den   (dn),
        .i_pay   (r_sc.m),
        .o_valid (d2_vld),
        .o_quo   (d2_quo),
        .o_pay   (d2_raw)
    );
    assign d2_mid = t_mid'(d2_raw);

    // Raise (1 - p) to the 64th power: six squarings.
    localparam logic [QuoW-1:0] One = QuoW'(1) << FracW;

    logic [QuoW-1:0] r_w   [NSq];
    t_mid            r_wm  [NSq];
    logic [NSq-1:0]  r_wv;
    logic [QuoW-1:0] n_w   [NSq];
    logic [QuoW-1:0] w0;

    assign w0 = (d2_quo >= One) ? '0 : (One - d2_quo);

    always_comb begin
        logic [2*QuoW-1:0] sq;
        for (int k = 0; k < NSq; k++) begin
            if (k == 0) sq = w0 * w0;
            else        sq = r_w[k-1] * r_w[k-1];
            n_w[k] = sq[FracW+QuoW-1:FracW];
        end
    end

    // Stage F: apply damping to the weight.
    logic              r_sf_vld;
    t_mid              r_sf;
    logic [2*QuoW-1:0] aw;
    t_mid              n_sf;

    assign aw = r_wm[NSq-1].a * r_w[NSq-1];

    always_comb begin
        n_sf = r_wm[NSq-1];
        if (r_wm[NSq-1].go) n_sf.a = aw[FracW+QuoW-1:FracW];
    end

    // Stage G: displacement, rounded half away from zero.
    logic                r_sg_vld;
    t_sg                 r_sg;
    t_sg                 n_sg;
    logic [CoordW:0]     magx, magy;
    logic [CoordW+QuoW-1:0] prx, pry;
    logic [CoordW:0]     dxv, dyv;

    assign magx = r_sf.mx[CoordW] ? (CoordW+1)'(-r_sf.mx) : (CoordW+1)'(r_sf.mx);
    assign magy = r_sf.my[CoordW] ? (CoordW+1)'(-r_sf.my) : (CoordW+1)'(r_sf.my);
    assign prx  = magx[CoordW-1:0] * r_sf.a + (CoordW+QuoW)'(1 << (FracW-1));
    assign pry  = magy[CoordW-1:0] * r_sf.a + (CoordW+QuoW)'(1 << (FracW-1));
    assign dxv  = prx[CoordW+QuoW-1:FracW];
    assign dyv  = pry[CoordW+QuoW-1:FracW];

    always_comb begin
        logic signed [CoordW+1:0] pxe, pye, dxe, dye;
        pxe = $signed({2'b00, r_sf.px});
        pye = $signed({2'b00, r_sf.py});
        dxe = $signed({1'b0, dxv});
        dye = $signed({1'b0, dyv});
        n_sg.rx      = pxe;
        n_sg.ry      = pye;
        n_sg.in_circ = r_sf.in_circ;
        if (r_sf.move) begin
            n_sg.rx = r_sf.mx[CoordW] ? (pxe + dxe) : (pxe - dxe);
            n_sg.ry = r_sf.my[CoordW] ? (pye + dye) : (pye - dye);
        end
    end

    // Clamp into the image.
    logic [CoordW-1:0] cl_x, cl_y;

    always_comb begin
        if (r_sg.rx[CoordW+1])                     cl_x = '0;
        else if (r_sg.rx[CoordW:0] > {1'b0, i_lim_x}) cl_x = i_lim_x;
        else                                       cl_x = r_sg.rx[CoordW-1:0];
        if (r_sg.ry[CoordW+1])                     cl_y = '0;
        else if (r_sg.ry[CoordW:0] > {1'b0, i_lim_y}) cl_y = i_lim_y;
        else                                       cl_y = r_sg.ry[CoordW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sa_vld    <= 1'b0;
            r_sb_vld    <= 1'b0;
            r_sc_vld    <= 1'b0;
            r_wv        <= '0;
            r_sf_vld    <= 1'b0;
            r_sg_vld    <= 1'b0;
            o_out_valid <= 1'b0;
        end else if (en) begin
            r_sa_vld    <= d1_vld;
            r_sb_vld    <= r_sa_vld;
            r_sc_vld    <= r_sb_vld;
            r_wv        <= {r_wv[NSq-2:0], d2_vld};
            r_sf_vld    <= r_wv[NSq-1];
            r_sg_vld    <= r_sf_vld;
            o_out_valid <= r_sg_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sa <= n_sa;
            r_sb <= n_sb;
            r_sc <= n_sc;
            r_w[0]  <= n_w[0];
            r_wm[0] <= d2_mid;
            for (int k = 1; k < NSq; k++) begin
                r_w[k]  <= n_w[k];
                r_wm[k] <= r_wm[k-1];
            end
            r_sf         <= n_sf;
            r_sg         <= n_sg;
            o_x_out      <= cl_x;
            o_y_out      <= cl_y;
            o_inside_res <= r_sg.in_circ;
        end
    end

`ifndef ASSERT_OFF
    a_x_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_x_out <= i_lim_x) else $error("x beat beyond clamp bound");
    a_y_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_y_out <= i_lim_y) else $error("y beat beyond clamp bound");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> $stable(r_sg_vld) && $stable(r_sf_vld))
        else $error("pipeline advanced under stall");
`endif

endmodule

/* design/local_translation_warp_top.sv */
`timescale 1ns / 1ps
// Top level of the local translation warp: config registers, front end,
// queue and back-end pipeline. Depends on ldw_pkg, ldw_front, ldw_fifo, ldw_back.
//
// Usage:
//   Input channel: i_in_valid / o_in_stall carry one source point (i_x_in, i_y_in,
//   unsigned Q12.4) per beat. Output channel: o_out_valid / i_out_stall carry the
//   warped point (o_x_out, o_y_out) and o_inside_res per beat, in input order.
//   Throughput: one beat per clock, sustained, while the receiver takes beats.
//   Path: with no stall, an accepted beat is written to the queue at the accepting
//   edge, then passes 25 stages in each of the two dividers, the projection setup
//   stages, six squarings for the damping power, weighting, displacement and the
//   output register, after which o_out_valid rises.
//   Config: write i_cfg_data to register i_cfg_idx while i_cfg_we is high; write
//   only while the block is drained.
//   Reset: synchronous, active low; clears the pipeline and queue and loads the
//   register defaults (zero drag and radius, 4096 x 4096 image).
//   Stall: a held output beat freezes the whole back end; the queue then fills
//   and o_in_stall rises once its four entries are taken.
module local_translation_warp_top (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [2:0]                 i_cfg_idx,
    input  logic [ldw_pkg::CoordW-1:0] i_cfg_data,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic [ldw_pkg::CoordW-1:0] i_x_in,
    input  logic [ldw_pkg::CoordW-1:0] i_y_in,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic [ldw_pkg::CoordW-1:0] o_x_out,
    output logic [ldw_pkg::CoordW-1:0] o_y_out,
    output logic                       o_inside_res
);
    import ldw_pkg::*;

    // Configuration registers.
    logic [CoordW-1:0] r_start_x, r_start_y, r_end_x, r_end_y, r_radius;
    logic              r_damp;
    logic [DimW-1:0]   r_width, r_height;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_x <= '0;
            r_start_y <= '0;
            r_end_x   <= '0;
            r_end_y   <= '0;
            r_radius  <= '0;
            r_damp    <= 1'b0;
            r_width   <= DimW'(MaxDim);
            r_height  <= DimW'(MaxDim);
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                REG_START_X: r_start_x <= i_cfg_data;
                REG_START_Y: r_start_y <= i_cfg_data;
                REG_END_X:   r_end_x   <= i_cfg_data;
                REG_END_Y:   r_end_y   <= i_cfg_data;
                REG_RADIUS:  r_radius  <= i_cfg_data;
                REG_DAMP:    r_damp    <= i_cfg_data[0];
                REG_WIDTH:   r_width   <= i_cfg_data[DimW-1:0];
                REG_HEIGHT:  r_height  <= i_cfg_data[DimW-1:0];
                default: ;
            endcase
        end
    end

    t_cfg cfg;
    always_comb begin
        cfg.start_x = r_start_x;
        cfg.start_y = r_start_y;
        cfg.end_x   = r_end_x;
        cfg.end_y   = r_end_y;
        cfg.radius  = r_radius;
        cfg.damp    = r_damp;
    end

    // Classify the incoming point.
    t_item front_item;

    ldw_front u_front (
        .i_x    (i_x_in),
        .i_y    (i_y_in),
        .i_cfg  (cfg),
        .o_item (front_item)
    );

    // Queue between front and back; stall the sender only when it is full.
    t_item q_item;
    logic  q_full, q_empty, q_pop, push;

    assign push       = i_in_valid && !q_full;
    assign o_in_stall = q_full;

    ldw_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (front_item),
        .i_pop   (q_pop),
        .o_data  (q_item),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    // Clamp bounds follow the image size registers.
    logic [CoordW-1:0] lim_x, lim_y;
    assign lim_x = clamp_limit(r_width);
    assign lim_y = clamp_limit(r_height);

    ldw_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_avail      (!q_empty),
        .i_item       (q_item),
        .o_pop        (q_pop),
        .i_lim_x      (lim_x),
        .i_lim_y      (lim_y),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_x_out      (o_x_out),
        .o_y_out      (o_y_out),
        .o_inside_res (o_inside_res)
    );

endmodule
